### hw/rtl/dome_mesh_index_generator_core_macros.svh
// Assertion helpers included by the generator core RTL.
`ifndef DOME_MESH_INDEX_GENERATOR_CORE_MACROS_SVH
`define DOME_MESH_INDEX_GENERATOR_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define DMIG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DMIG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dmig_pkg.sv
package dmig_pkg;

  localparam int MAX_SUBDIVISION = 8;

  localparam int K_W   = MAX_SUBDIVISION;
  localparam int N_W   = MAX_SUBDIVISION + 1;
  localparam int IDX_W = 18;
  localparam int SUB_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  typedef logic [K_W-1:0]   count_t;
  typedef logic [N_W-1:0]   len_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       phase_t;
  typedef logic [1:0]       quarter_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_SUBDIVISION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEAM        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_MODE   = 2'd2;

  localparam phase_t PH_A = 2'd0;
  localparam phase_t PH_B = 2'd1;
  localparam phase_t PH_C = 2'd2;
  localparam phase_t PH_D = 2'd3;

  localparam quarter_t QUARTER_LAST = 2'd3;

  localparam logic [SUB_W-1:0] SUB_MIN = 4'd1;
  localparam logic [SUB_W-1:0] SUB_MAX = SUB_W'(MAX_SUBDIVISION);

endpackage

### hw/rtl/dome_mesh_index_generator_core.sv
// Dome mesh index generator.
// Each transfer on the input channel (in_valid, in_stall, in_restart) asks for one
// primitive of the index list of a subdivided hemispherical dome; in_restart set
// returns the walk to the first primitive. Each request yields exactly one result
// transfer on the output channel: three vertex indices (the third is zero for
// line pairs) and a flag on the final primitive of the mesh. After the final
// primitive the walk starts over.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// subdivision, seam vertices and line mode; cfg_ready is always high. The user must
// make writes only while no request is in flight; the block does not enforce it.
// A request passes an input register, a ring offset stage with three small
// multipliers and an index stage whose register drives the outputs. One request
// is taken every cycle while in_stall is low.
// When the receiver stalls, the result holds and the stages behind it fill;
// in_stall rises only when all three stages hold data and out_stall is high.
// Reset selects subdivision 1, no seams, triangle mode, the first primitive,
// and empties the pipeline.
`include "dome_mesh_index_generator_core_macros.svh"

module dome_mesh_index_generator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dmig_pkg::IDX_W-1:0]            out_index_a,
  output logic [dmig_pkg::IDX_W-1:0]            out_index_b,
  output logic [dmig_pkg::IDX_W-1:0]            out_index_c,
  output logic                                  out_last_primitive,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dmig_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dmig_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int FAC_W  = dmig_pkg::N_W + 2;
  localparam int PROD_W = dmig_pkg::IDX_W;

  logic [dmig_pkg::SUB_W-1:0] subdivision_r;
  logic                       seam_r;
  logic                       line_r;

  dmig_pkg::count_t   k_r, k_nxt;
  dmig_pkg::quarter_t q_r, q_nxt;
  dmig_pkg::count_t   s_r, s_nxt;
  dmig_pkg::phase_t   p_r, p_nxt;

  logic               a_v_r;
  dmig_pkg::count_t   a_k_r;
  dmig_pkg::quarter_t a_q_r;
  dmig_pkg::count_t   a_s_r;
  dmig_pkg::phase_t   a_p_r;
  logic               a_last_r;

  logic               b_v_r;
  dmig_pkg::idx_t     b_rk_r, b_rk1_r, b_rk2_r, b_f_r, b_fn_r;
  dmig_pkg::count_t   b_s_r;
  dmig_pkg::phase_t   b_p_r;
  logic               b_last_r;

  logic               o_v_r;
  dmig_pkg::idx_t     o_a_r, o_b_r, o_c_r;
  logic               o_last_r;

  logic en_o, en_b, en_a, in_acc;

  logic [dmig_pkg::SUB_W-1:0] sub_eff;
  dmig_pkg::len_t n_w;

  dmig_pkg::len_t len_c, len_e;
  logic           st_valid, s_end_c, s_end_e, closing, last_e;
  dmig_pkg::count_t   ek, es;
  dmig_pkg::quarter_t eq;
  dmig_pkg::phase_t   ep;
  dmig_pkg::len_t     ek1;

  dmig_pkg::len_t      len_b;
  logic [FAC_W-1:0]    fac_b;
  logic [PROD_W-1:0]   prod_b;
  dmig_pkg::idx_t      rk_b, vck_b, d2_b, qoff_b, qoff1_b;

  dmig_pkg::idx_t sa, sb, sc, sd, ta, tb, tc, td;
  dmig_pkg::idx_t oa_nxt, ob_nxt, oc_nxt;

  assign en_o     = !o_v_r || !out_stall;
  assign en_b     = !b_v_r || en_o;
  assign en_a     = !a_v_r || en_b;
  assign in_stall = !en_a;
  assign in_acc   = in_valid && en_a;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (subdivision_r < dmig_pkg::SUB_MIN) begin
      sub_eff = dmig_pkg::SUB_MIN;
    end else if (subdivision_r > dmig_pkg::SUB_MAX) begin
      sub_eff = dmig_pkg::SUB_MAX;
    end else begin
      sub_eff = subdivision_r;
    end
    n_w = dmig_pkg::N_W'(1) << sub_eff;
  end

  // Counters left stale by a register write act as a restart.
  always_comb begin
    len_c   = n_w - dmig_pkg::N_W'(k_r);
    s_end_c = (dmig_pkg::N_W'(s_r) == len_c - dmig_pkg::N_W'(1));
    if ((dmig_pkg::N_W'(k_r) >= n_w) || (dmig_pkg::N_W'(s_r) >= len_c)) begin
      st_valid = 1'b0;
    end else if (line_r) begin
      if (p_r == dmig_pkg::PH_A) begin
        st_valid = (s_r == '0);
      end else if (s_end_c) begin
        st_valid = (p_r == dmig_pkg::PH_B);
      end else begin
        st_valid = 1'b1;
      end
    end else begin
      if (p_r == dmig_pkg::PH_C || p_r == dmig_pkg::PH_D) begin
        st_valid = 1'b0;
      end else if (s_end_c) begin
        st_valid = (p_r == dmig_pkg::PH_A);
      end else begin
        st_valid = 1'b1;
      end
    end

    if (in_restart || !st_valid) begin
      ek = '0;
      eq = '0;
      es = '0;
      ep = dmig_pkg::PH_A;
    end else begin
      ek = k_r;
      eq = q_r;
      es = s_r;
      ep = p_r;
    end

    len_e   = n_w - dmig_pkg::N_W'(ek);
    s_end_e = (dmig_pkg::N_W'(es) == len_e - dmig_pkg::N_W'(1));
    closing = line_r ? (ep == dmig_pkg::PH_B && s_end_e) : s_end_e;
    last_e  = closing && (dmig_pkg::N_W'(ek) == n_w - dmig_pkg::N_W'(1)) &&
              (eq == dmig_pkg::QUARTER_LAST);
    ek1     = dmig_pkg::N_W'(ek) + dmig_pkg::N_W'(1);

    k_nxt = ek;
    q_nxt = eq;
    s_nxt = es;
    p_nxt = ep;
    if (closing) begin
      s_nxt = '0;
      p_nxt = dmig_pkg::PH_A;
      if (eq == dmig_pkg::QUARTER_LAST) begin
        q_nxt = '0;
        k_nxt = (ek1 >= n_w) ? '0 : dmig_pkg::K_W'(ek1);
      end else begin
        q_nxt = eq + 2'd1;
      end
    end else if (line_r) begin
      if (ep == dmig_pkg::PH_D) begin
        p_nxt = dmig_pkg::PH_B;
        s_nxt = es + dmig_pkg::K_W'(1);
      end else begin
        p_nxt = ep + 2'd1;
      end
    end else begin
      if (ep == dmig_pkg::PH_A) begin
        p_nxt = dmig_pkg::PH_B;
      end else begin
        p_nxt = dmig_pkg::PH_A;
        s_nxt = es + dmig_pkg::K_W'(1);
      end
    end
  end

  // Ring start R(k) = k * (4N + 2 + seam - 2k); R(k+1) = R(k) + 4(N-k) + seam.
  always_comb begin
    len_b   = n_w - dmig_pkg::N_W'(a_k_r);
    fac_b   = (FAC_W'(n_w) << 2) + FAC_W'(2) + FAC_W'(seam_r) - (FAC_W'(a_k_r) << 1);
    prod_b  = PROD_W'(a_k_r) * PROD_W'(fac_b);
    rk_b    = dmig_pkg::IDX_W'(prod_b);
    vck_b   = (dmig_pkg::IDX_W'(len_b) << 2) + dmig_pkg::IDX_W'(seam_r);
    d2_b    = (dmig_pkg::IDX_W'(len_b) << 3) - dmig_pkg::IDX_W'(4) +
              (dmig_pkg::IDX_W'(seam_r) << 1);
    qoff_b  = dmig_pkg::IDX_W'(a_q_r) * dmig_pkg::IDX_W'(len_b);
    qoff1_b = dmig_pkg::IDX_W'(a_q_r) * (dmig_pkg::IDX_W'(len_b) - dmig_pkg::IDX_W'(1));
  end

  always_comb begin
    sa = b_f_r + dmig_pkg::IDX_W'(b_s_r);
    sb = b_f_r + dmig_pkg::IDX_W'(b_s_r) + dmig_pkg::IDX_W'(1);
    sc = b_fn_r + dmig_pkg::IDX_W'(b_s_r);
    sd = b_fn_r + dmig_pkg::IDX_W'(b_s_r) + dmig_pkg::IDX_W'(1);
    ta = (!seam_r && sa == b_rk1_r) ? b_rk_r  : sa;
    tb = (!seam_r && sb == b_rk1_r) ? b_rk_r  : sb;
    tc = (!seam_r && sc == b_rk2_r) ? b_rk1_r : sc;
    td = (!seam_r && sd == b_rk2_r) ? b_rk1_r : sd;

    oc_nxt = '0;
    if (line_r) begin
      case (b_p_r)
        dmig_pkg::PH_A: begin
          oa_nxt = ta;
          ob_nxt = tc;
        end
        dmig_pkg::PH_B: begin
          oa_nxt = ta;
          ob_nxt = tb;
        end
        dmig_pkg::PH_C: begin
          oa_nxt = tb;
          ob_nxt = tc;
        end
        default: begin
          oa_nxt = tb;
          ob_nxt = td;
        end
      endcase
    end else begin
      case (b_p_r)
        dmig_pkg::PH_A: begin
          oa_nxt = ta;
          ob_nxt = tc;
          oc_nxt = tb;
        end
        default: begin
          oa_nxt = tb;
          ob_nxt = tc;
          oc_nxt = td;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subdivision_r <= dmig_pkg::SUB_MIN;
      seam_r        <= 1'b0;
      line_r        <= 1'b0;
      k_r           <= '0;
      q_r           <= '0;
      s_r           <= '0;
      p_r           <= dmig_pkg::PH_A;
      a_v_r         <= 1'b0;
      b_v_r         <= 1'b0;
      o_v_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dmig_pkg::CFG_SUBDIVISION: subdivision_r <= cfg_data;
          dmig_pkg::CFG_SEAM:        seam_r        <= cfg_data[0];
          dmig_pkg::CFG_LINE_MODE:   line_r        <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        k_r <= k_nxt;
        q_r <= q_nxt;
        s_r <= s_nxt;
        p_r <= p_nxt;
      end
      if (en_a) begin
        a_v_r <= in_valid;
      end
      if (en_b) begin
        b_v_r <= a_v_r;
      end
      if (en_o) begin
        o_v_r <= b_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_k_r    <= ek;
      a_q_r    <= eq;
      a_s_r    <= es;
      a_p_r    <= ep;
      a_last_r <= last_e;
    end
    if (en_b && a_v_r) begin
      b_rk_r   <= rk_b;
      b_rk1_r  <= rk_b + vck_b;
      b_rk2_r  <= rk_b + d2_b;
      b_f_r    <= rk_b + qoff_b;
      b_fn_r   <= rk_b + (vck_b + qoff1_b);
      b_s_r    <= a_s_r;
      b_p_r    <= a_p_r;
      b_last_r <= a_last_r;
    end
    if (en_o && b_v_r) begin
      o_a_r    <= oa_nxt;
      o_b_r    <= ob_nxt;
      o_c_r    <= oc_nxt;
      o_last_r <= b_last_r;
    end
  end

  assign out_valid          = o_v_r;
  assign out_index_a        = o_a_r;
  assign out_index_b        = o_b_r;
  assign out_index_c        = o_c_r;
  assign out_last_primitive = o_last_r;

  `DMIG_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, rst_n && in_acc, a_v_r,
    "accepted request did not reach the input stage")
  `DMIG_ASSERT_NEXT(a_restart_first, clk, rst_n, rst_n && in_acc && in_restart,
    a_k_r == '0 && a_q_r == '0 && a_s_r == '0 && a_p_r == dmig_pkg::PH_A,
    "restart did not select the first primitive")
  `DMIG_ASSERT_NEXT(a_stage_holds, clk, rst_n, rst_n && a_v_r && !en_b, a_v_r,
    "input stage dropped a request while blocked")
  `DMIG_ASSERT_SAME(a_stall_only_full, clk, rst_n, in_stall,
    a_v_r && b_v_r && o_v_r && out_stall,
    "input stalled while the pipeline had room")

endmodule
